[hw/rtl/sab_pkg.sv]
package sab_pkg;

    localparam int DATA_W        = 32;
    localparam int POS_W         = 10;
    localparam int IDX_W         = 10;
    localparam int LEN_W         = 11;
    localparam int MODE_W        = 2;
    localparam int DEPTH_DEFAULT = 1024;

    typedef enum logic {
        ACT_WRITE  = 1'b0,
        ACT_SEARCH = 1'b1
    } t_action;

    // Code 3 carries no meaning and falls back to any-match
    typedef enum logic [MODE_W-1:0] {
        MODE_ANY   = 2'd0,
        MODE_FIRST = 2'd1,
        MODE_LAST  = 2'd2
    } t_mode;

endpackage

[hw/rtl/sab_ram.sv]
module sab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/sab_ctrl.sv]
module sab_ctrl #(
    parameter int DEPTH = sab_pkg::DEPTH_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [sab_pkg::MODE_W-1:0]   i_mode,
    input  logic [sab_pkg::DATA_W-1:0]   i_key,
    input  logic [$clog2(DEPTH+1)-1:0]   i_len,
    output logic                         o_busy,
    output logic                         o_rd_en,
    output logic [$clog2(DEPTH)-1:0]     o_rd_addr,
    input  logic [sab_pkg::DATA_W-1:0]   i_rd_data,
    output logic                         o_valid,
    output logic                         o_found,
    output logic [sab_pkg::IDX_W-1:0]    o_index
);

    import sab_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CHECK
    } t_state;

    t_state              r_state, n_state;
    logic [LW-1:0]       r_lo, n_lo;
    logic [LW-1:0]       r_hi, n_hi;       // exclusive upper bound
    logic [AW-1:0]       r_mid, n_mid;
    logic [AW-1:0]       r_where, n_where;
    logic                r_hit, n_hit;
    logic [DATA_W-1:0]   r_key, n_key;
    logic [MODE_W-1:0]   r_mode, n_mode;
    logic                r_valid, n_valid;
    logic                r_found, n_found;
    logic [IDX_W-1:0]    r_index, n_index;

    logic [LW:0]         w_sum;
    logic [AW-1:0]       w_mid;
    logic [LW-1:0]       w_mid_inc;
    logic                w_eq;
    logic                w_gt;

    // Midpoint of the inclusive range [lo, hi-1], rounded down
    assign w_sum     = (LW+1)'(r_lo) + (LW+1)'(r_hi) - (LW+1)'(1);
    assign w_mid     = AW'(w_sum >> 1);
    assign w_mid_inc = LW'(r_mid) + LW'(1);
    assign w_eq      = (i_rd_data == r_key);
    assign w_gt      = ($signed(i_rd_data) > $signed(r_key));

    always_comb begin
        n_state   = r_state;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_where   = r_where;
        n_hit     = r_hit;
        n_key     = r_key;
        n_mode    = r_mode;
        n_valid   = 1'b0;
        n_found   = r_found;
        n_index   = r_index;
        o_rd_en   = 1'b0;
        o_rd_addr = w_mid;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_lo    = '0;
                    n_hi    = i_len;
                    n_hit   = 1'b0;
                    n_where = '0;
                    n_key   = i_key;
                    n_mode  = i_mode;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (r_lo < r_hi) begin
                    o_rd_en = 1'b1;
                    n_mid   = w_mid;
                    n_state = S_CHECK;
                end else begin
                    n_valid = 1'b1;
                    n_found = r_hit;
                    n_index = r_hit ? IDX_W'(r_where) : '0;
                    n_state = S_IDLE;
                end
            end
            S_CHECK: begin
                n_state = S_PROBE;
                if (w_eq) begin
                    n_hit   = 1'b1;
                    n_where = r_mid;
                    case (r_mode)
                        MODE_FIRST: n_hi = LW'(r_mid);
                        MODE_LAST:  n_lo = w_mid_inc;
                        default: begin
                            // any match: stop at this probe
                            n_valid = 1'b1;
                            n_found = 1'b1;
                            n_index = IDX_W'(r_mid);
                            n_state = S_IDLE;
                        end
                    endcase
                end else if (w_gt) begin
                    n_hi = LW'(r_mid);
                end else begin
                    n_lo = w_mid_inc;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_where <= n_where;
        r_hit   <= n_hit;
        r_key   <= n_key;
        r_mode  <= n_mode;
        r_found <= n_found;
        r_index <= n_index;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_found = r_found;
    assign o_index = r_index;

endmodule

[hw/rtl/sorted_array_binary_search_core.sv]
// Binary search over a sorted store of DEPTH signed 32-bit words. A write request
// (action 0) stores value at position and gives no result; positions at or beyond
// DEPTH are dropped. Fill positions 0 to length-1 in ascending order before
// searching. A search request (action 1) bisects positions 0 to length-1 (length
// saturates at DEPTH) and returns found and index on a single o_valid strobe; mode
// 1 returns the lowest matching index, mode 2 the highest, any other mode the first
// probe that matches. The receiver cannot stall: sample the result in the strobe
// cycle. Each probe reads the store through its read port in the probe state and
// compares the registered word in the check state; a search makes at most
// floor(log2(length)) + 1 probes, and no new request is taken while busy is high.
// Write length only while busy is low and no search is pending.
module sorted_array_binary_search_core #(
    parameter int DEPTH = sab_pkg::DEPTH_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_action,
    input  logic [sab_pkg::MODE_W-1:0]  i_mode,
    input  logic [sab_pkg::POS_W-1:0]   i_position,
    input  logic [sab_pkg::DATA_W-1:0]  i_value,
    input  logic                        i_cfg_wr_en,
    input  logic [sab_pkg::LEN_W-1:0]   i_cfg_wr_data,
    output logic                        o_valid,
    output logic                        o_found,
    output logic [sab_pkg::IDX_W-1:0]   o_index
);

    import sab_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    logic [LEN_W-1:0]  r_length;
    logic [LW-1:0]     w_len;
    logic              w_accept;
    logic              w_wr_en;
    logic              w_search;
    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;
    logic [DATA_W-1:0] w_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= '0;
        end else if (i_cfg_wr_en) begin
            r_length <= i_cfg_wr_data;
        end
    end

    assign w_len    = (32'(r_length) > 32'(DEPTH)) ? LW'(DEPTH) : LW'(r_length);
    assign w_accept = start && !busy;
    assign w_search = w_accept && (i_action == ACT_SEARCH);
    assign w_wr_en  = w_accept && (i_action == ACT_WRITE)
                      && (32'(i_position) < 32'(DEPTH));

    sab_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (AW'(i_position)),
        .i_wr_data (i_value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    sab_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_search),
        .i_mode    (i_mode),
        .i_key     (i_value),
        .i_len     (w_len),
        .o_busy    (busy),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_valid   (o_valid),
        .o_found   (o_found),
        .o_index   (o_index)
    );

`ifndef SYNTHESIS
    a_search_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_search |=> busy)
        else $error("search request did not start the sequencer");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_action == ACT_WRITE)) |=> !o_valid)
        else $error("write request produced a result");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a search in flight");

    a_miss_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_index == '0))
        else $error("miss reported a nonzero index");
`endif

endmodule
